// ===== rtl/handheld_sound_generator_three_channel_top_macros.svh =====
// Assertion macros shared by the sound generator RTL.
// Each macro expands to one concurrent assertion on clk, disabled while arst_n is low.
`ifndef HANDHELD_SOUND_GENERATOR_THREE_CHANNEL_TOP_MACROS_SVH
`define HANDHELD_SOUND_GENERATOR_THREE_CHANNEL_TOP_MACROS_SVH

// same-cycle implication
`define HSG3_CHK_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define HSG3_CHK_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/hsg3_pkg.sv =====
// Package for the three-channel sound generator: payload types, register
// indexes, reset values and the small constant tables. No dependencies.
package hsg3_pkg;

	localparam int WAVE_BYTES          = 16;
	localparam int WAVE_AW             = 4;
	localparam int PHASE_FRACTION_BITS = 16;
	localparam int REG_NUM             = 13;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic CFG_CLOCKS = 1'b0;
	localparam logic CFG_FRAMES = 1'b1;

	localparam logic [3:0] IDX_NR10 = 4'd0;
	localparam logic [3:0] IDX_NR11 = 4'd1;
	localparam logic [3:0] IDX_NR12 = 4'd2;
	localparam logic [3:0] IDX_NR13 = 4'd3;
	localparam logic [3:0] IDX_NR14 = 4'd4;
	localparam logic [3:0] IDX_NR21 = 4'd5;
	localparam logic [3:0] IDX_NR22 = 4'd6;
	localparam logic [3:0] IDX_NR23 = 4'd7;
	localparam logic [3:0] IDX_NR24 = 4'd8;
	localparam logic [3:0] IDX_NR30 = 4'd9;
	localparam logic [3:0] IDX_NR32 = 4'd10;
	localparam logic [3:0] IDX_NR33 = 4'd11;
	localparam logic [3:0] IDX_NR34 = 4'd12;

	localparam logic [5:0] OFF_NR31     = 6'd11;
	localparam logic [5:0] OFF_WAVE_LO  = 6'd32;
	localparam logic [5:0] OFF_WAVE_HI  = 6'd47;

	localparam logic [7:0] REG_RESET [REG_NUM] = '{
		8'h80, 8'hBF, 8'hF3, 8'h00, 8'hBF, 8'h3F, 8'h00, 8'h00, 8'hBF,
		8'h7F, 8'h9F, 8'h00, 8'hBF
	};

	localparam logic [23:0] FILTER_K  = 24'd16776511;
	localparam logic [30:0] DIV15_M   = 31'd1145324613;
	localparam logic [23:0] CAP_RESET = 24'h200000;

	typedef struct packed {
		logic       opcode;
		logic [5:0] reg_offset;
		logic [7:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] audio_sample;
		logic [2:0]         channels_active;
	} out_item_t;

	function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
		logic [7:0] p;
		unique case (sel)
			2'd0: p = 8'h08;
			2'd1: p = 8'h0C;
			2'd2: p = 8'h3C;
			default: p = 8'hF3;
		endcase
		return p;
	endfunction

	function automatic logic signed [15:0] wave_level(input logic [3:0] nib);
		logic signed [15:0] l;
		unique case (nib)
			4'd0:  l = -16'sd8192;
			4'd1:  l = -16'sd7022;
			4'd2:  l = -16'sd5851;
			4'd3:  l = -16'sd4681;
			4'd4:  l = -16'sd3511;
			4'd5:  l = -16'sd2341;
			4'd6:  l = -16'sd1170;
			4'd7:  l = 16'sd0;
			4'd8:  l = 16'sd1170;
			4'd9:  l = 16'sd2341;
			4'd10: l = 16'sd3511;
			4'd11: l = 16'sd4681;
			4'd12: l = 16'sd5851;
			4'd13: l = 16'sd7022;
			4'd14: l = 16'sd8192;
			default: l = 16'sd9362;
		endcase
		return l;
	endfunction

	function automatic logic [11:0] sweep_next(input logic [10:0] sh, input logic [7:0] nr10);
		logic [10:0] delta;
		delta = sh >> nr10[2:0];
		return nr10[3] ? ({1'b0, sh} - {1'b0, delta}) : ({1'b0, sh} + {1'b0, delta});
	endfunction

endpackage

// ===== rtl/hsg3_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hsg3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/handheld_sound_generator_three_channel_top.sv =====
// Top level of the three-channel sound generator; uses hsg3_pkg, hsg3_ram
// and the assertion macros header.
//
// A register write transfer leaves the block in S_IDLE. A sample tick runs these states
// before the next input transfer: S_CH in the shared channel phase unit (one pass per
// channel, the wave nibble read from the wave RAM), S_FRAME in the sequencer, S_MIX,
// S_DIV, S_SUB, S_FILT and S_CAP through the mix divider and the filter multiplier, then
// S_DONE, where the result enters the output register. A tick also waits there while the
// previous result is still stalled. After reset the block accepts input at once.
module handheld_sound_generator_three_channel_top #(
	parameter int PHASE_FRACTION_BITS = hsg3_pkg::PHASE_FRACTION_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  hsg3_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output hsg3_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [25:0]         cfg_data
);

`include "handheld_sound_generator_three_channel_top_macros.svh"

	localparam int PF    = PHASE_FRACTION_BITS;
	localparam int ACC_W = PF + 16;
	localparam logic signed [ACC_W-1:0] ACC_FLOOR = {3'b111, {(PF + 13){1'b0}}};

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CH    = 9'b000000010,
		S_FRAME = 9'b000000100,
		S_MIX   = 9'b000001000,
		S_DIV   = 9'b000010000,
		S_SUB   = 9'b000100000,
		S_FILT  = 9'b001000000,
		S_CAP   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	function automatic logic signed [ACC_W-1:0] period_of(input logic [10:0] f,
			input logic wave);
		logic [11:0] b;
		b = 12'd2048 - {1'b0, f};
		return wave ? (ACC_W'({b, 1'b0}) << PF) : (ACC_W'({b, 2'b00}) << PF);
	endfunction

	state_t state_q;
	logic [1:0] ch_q;
	logic [25:0] cps_q;
	logic [23:0] fps_q;
	logic [7:0] regs_q [hsg3_pkg::REG_NUM];
	logic [hsg3_pkg::WAVE_BYTES-1:0] wvld_q;
	logic signed [ACC_W-1:0] acc_q [3];
	logic [2:0] duty_q [2];
	logic [4:0] wave_pos_q;
	logic [8:0] len_q [3];
	logic [3:0] vol_q [2];
	logic [2:0] etm_q [2];
	logic [10:0] shadow_q;
	logic [3:0] sw_timer_q;
	logic sw_active_q;
	logic [2:0] en_q;
	logic signed [15:0] held_q [3];
	logic signed [25:0] facc_q;
	logic [2:0] fs_q;
	logic signed [23:0] cap_q;

	logic signed [21:0] sum_s1;
	logic signed [23:0] wt_s1;
	logic [60:0] prod_s2;
	logic signed [23:0] mix_s3;
	logic signed [24:0] o_s3;
	logic signed [49:0] ok_s4;
	hsg3_pkg::out_item_t res_q;
	logic out_valid_q;
	hsg3_pkg::out_item_t out_q;

	logic in_acc, wr_acc, tk_acc;
	logic [5:0] off;
	logic [7:0] wd;
	logic w_wave, w_hit, trig, t_dis;
	logic [3:0] w_idx;
	logic [1:0] t_ch;
	logic [10:0] t_f;
	logic [7:0] t_env;
	logic [7:0] ram_rd;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign wr_acc = in_acc && (in_data.opcode == hsg3_pkg::OP_WRITE);
	assign tk_acc = in_acc && (in_data.opcode == hsg3_pkg::OP_TICK);
	assign off = in_data.reg_offset;
	assign wd = in_data.write_data;
	assign w_wave = (off >= hsg3_pkg::OFF_WAVE_LO) && (off <= hsg3_pkg::OFF_WAVE_HI);

	always_comb begin
		w_hit = 1'b1;
		w_idx = hsg3_pkg::IDX_NR10;
		priority if (off <= 6'd4) begin
			w_idx = off[3:0];
		end else if (off >= 6'd6 && off <= 6'd9) begin
			w_idx = 4'(off - 6'd1);
		end else if (off == 6'd10) begin
			w_idx = hsg3_pkg::IDX_NR30;
		end else if (off >= 6'd12 && off <= 6'd14) begin
			w_idx = 4'(off - 6'd2);
		end else begin
			w_hit = 1'b0;
		end
	end

	always_comb begin
		t_ch = 2'd0;
		t_f = {wd[2:0], regs_q[hsg3_pkg::IDX_NR13]};
		t_env = regs_q[hsg3_pkg::IDX_NR12];
		if (w_idx == hsg3_pkg::IDX_NR24) begin
			t_ch = 2'd1;
			t_f = {wd[2:0], regs_q[hsg3_pkg::IDX_NR23]};
			t_env = regs_q[hsg3_pkg::IDX_NR22];
		end else if (w_idx == hsg3_pkg::IDX_NR34) begin
			t_ch = 2'd2;
			t_f = {wd[2:0], regs_q[hsg3_pkg::IDX_NR33]};
		end
		trig = w_hit && wd[7] && (w_idx == hsg3_pkg::IDX_NR14 ||
			w_idx == hsg3_pkg::IDX_NR24 || w_idx == hsg3_pkg::IDX_NR34);
		t_dis = (t_ch == 2'd0) && (regs_q[hsg3_pkg::IDX_NR10][2:0] != 3'd0) &&
			(hsg3_pkg::sweep_next(t_f, regs_q[hsg3_pkg::IDX_NR10]) > 12'd2047);
	end

	hsg3_ram #(
		.WIDTH(8),
		.DEPTH(hsg3_pkg::WAVE_BYTES)
	) u_wave_ram (
		.clk  (clk),
		.we   (wr_acc && w_wave),
		.waddr(off[hsg3_pkg::WAVE_AW-1:0]),
		.wdata(wd),
		.raddr(wave_pos_q[4:1]),
		.rdata(ram_rd)
	);

	// channel phase unit
	logic signed [ACC_W-1:0] step, acc_sub, acc_add, acc_new, period;
	logic fire, ch_on;
	logic [7:0] ch_lo, ch_hi, pat, wbyte;
	logic [2:0] dpos;
	logic [3:0] nib;
	logic signed [15:0] lvl;

	assign step = ACC_W'({cps_q, {PF{1'b0}}} >> 16);

	always_comb begin
		unique case (ch_q)
			2'd0: begin
				ch_lo = regs_q[hsg3_pkg::IDX_NR13];
				ch_hi = regs_q[hsg3_pkg::IDX_NR14];
				pat = hsg3_pkg::duty_pattern(regs_q[hsg3_pkg::IDX_NR11][7:6]);
			end
			2'd1: begin
				ch_lo = regs_q[hsg3_pkg::IDX_NR23];
				ch_hi = regs_q[hsg3_pkg::IDX_NR24];
				pat = hsg3_pkg::duty_pattern(regs_q[hsg3_pkg::IDX_NR21][7:6]);
			end
			default: begin
				ch_lo = regs_q[hsg3_pkg::IDX_NR33];
				ch_hi = regs_q[hsg3_pkg::IDX_NR34];
				pat = 8'h00;
			end
		endcase
		period = period_of({ch_hi[2:0], ch_lo}, ch_q == 2'd2);
		acc_sub = acc_q[ch_q] - step;
		fire = acc_sub[ACC_W-1] || (acc_sub == '0);
		acc_add = fire ? (acc_sub + period) : acc_sub;
		acc_new = (acc_add < ACC_FLOOR) ? ACC_FLOOR : acc_add;
		ch_on = en_q[ch_q];
		dpos = duty_q[ch_q[0]];
		wbyte = wvld_q[wave_pos_q[4:1]] ? ram_rd : 8'h00;
		nib = wave_pos_q[0] ? wbyte[3:0] : wbyte[7:4];
		if (ch_q == 2'd2) begin
			lvl = (ch_on && regs_q[hsg3_pkg::IDX_NR30][7]) ? hsg3_pkg::wave_level(nib) :
				16'sd0;
		end else begin
			lvl = !ch_on ? 16'sd0 : (pat[3'd7 - dpos] ? 16'sd8192 : -16'sd8192);
		end
	end

	// frame sequencer
	logic signed [25:0] facc_sub, facc_nx;
	logic fr_fire;
	logic [2:0] fs_nx;
	logic [8:0] len_nx [3];
	logic [2:0] en_nx;
	logic [7:0] r3_nx, r4_nx, nr10, env_c;
	logic [10:0] shadow_nx;
	logic [3:0] swt_nx, per8;
	logic [11:0] sn1, sn2;
	logic [3:0] vol_nx [2];
	logic [2:0] etm_nx [2];
	logic [7:0] hi_c [3];

	assign hi_c[0] = regs_q[hsg3_pkg::IDX_NR14];
	assign hi_c[1] = regs_q[hsg3_pkg::IDX_NR24];
	assign hi_c[2] = regs_q[hsg3_pkg::IDX_NR34];

	always_comb begin
		facc_sub = facc_q - 26'(signed'({1'b0, fps_q}));
		fr_fire = facc_sub[25] || (facc_sub == '0);
		facc_nx = fr_fire ? (facc_sub + 26'sd16777216) : facc_sub;
		fs_nx = fs_q + 3'd1;
		en_nx = en_q;
		nr10 = regs_q[hsg3_pkg::IDX_NR10];
		r3_nx = regs_q[hsg3_pkg::IDX_NR13];
		r4_nx = regs_q[hsg3_pkg::IDX_NR14];
		shadow_nx = shadow_q;
		swt_nx = sw_timer_q;
		per8 = (nr10[6:4] != 3'd0) ? {1'b0, nr10[6:4]} : 4'd8;
		sn1 = hsg3_pkg::sweep_next(shadow_q, nr10);
		sn2 = hsg3_pkg::sweep_next(sn1[10:0], nr10);
		env_c = 8'h00;
		for (int c = 0; c < 3; c++) begin
			len_nx[c] = len_q[c];
			if (fs_nx[0] && hi_c[c][6] && len_q[c] != 9'd0) begin
				len_nx[c] = len_q[c] - 9'd1;
				if (len_nx[c] == 9'd0) begin
					en_nx[c] = 1'b0;
				end
			end
		end
		if (fs_nx == 3'd2 || fs_nx == 3'd6) begin
			if (swt_nx != 4'd0) begin
				swt_nx = swt_nx - 4'd1;
			end
			if (swt_nx == 4'd0) begin
				swt_nx = per8;
				if (sw_active_q && nr10[6:4] != 3'd0) begin
					if (sn1 > 12'd2047) begin
						en_nx[0] = 1'b0;
					end else if (nr10[2:0] != 3'd0) begin
						r3_nx = sn1[7:0];
						r4_nx = {r4_nx[7:3], sn1[10:8]};
						shadow_nx = sn1[10:0];
						if (sn2 > 12'd2047) begin
							en_nx[0] = 1'b0;
						end
					end
				end
			end
		end
		for (int c = 0; c < 2; c++) begin
			vol_nx[c] = vol_q[c];
			etm_nx[c] = etm_q[c];
			env_c = (c == 0) ? regs_q[hsg3_pkg::IDX_NR12] : regs_q[hsg3_pkg::IDX_NR22];
			if (fs_nx == 3'd4 && env_c[2:0] != 3'd0) begin
				etm_nx[c] = etm_q[c] - 3'd1;
				if (etm_nx[c] == 3'd0) begin
					etm_nx[c] = env_c[2:0];
					if (env_c[3] && vol_q[c] != 4'd15) begin
						vol_nx[c] = vol_q[c] + 4'd1;
					end else if (!env_c[3] && vol_q[c] != 4'd0) begin
						vol_nx[c] = vol_q[c] - 4'd1;
					end
				end
			end
		end
	end

	// mix and filter datapath
	logic signed [21:0] p0, p1;
	logic signed [23:0] h2x;
	logic signed [31:0] zs;
	logic signed [27:0] mixw, capw;
	logic signed [49:0] fsh;
	logic signed [25:0] s15w;
	logic signed [23:0] cap_nx;
	logic signed [15:0] s15;

	always_comb begin
		p0 = 22'(held_q[0]) * 22'(signed'({1'b0, vol_q[0]}));
		p1 = 22'(held_q[1]) * 22'(signed'({1'b0, vol_q[1]}));
		h2x = 24'(held_q[2]);
		zs = (32'(sum_s1) <<< 7) + 32'sd7 + 32'sd503316480;
		mixw = signed'({2'b00, prod_s2[59:34]}) - 28'sd33554432 + 28'(wt_s1);
		fsh = (ok_s4 + 50'sd8388608) >>> 24;
		capw = 28'(mix_s3) - 28'(fsh);
		priority if (capw > 28'sd8388607) begin
			cap_nx = 24'sh7FFFFF;
		end else if (capw < -28'sd8388608) begin
			cap_nx = -24'sh800000;
		end else begin
			cap_nx = capw[23:0];
		end
		s15w = (26'(o_s3) + 26'sd64) >>> 7;
		priority if (s15w > 26'sd32767) begin
			s15 = 16'sh7FFF;
		end else if (s15w < -26'sd32768) begin
			s15 = -16'sh8000;
		end else begin
			s15 = s15w[15:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_MIX: begin
				sum_s1 <= p0 + p1;
				unique case (regs_q[hsg3_pkg::IDX_NR32][6:5])
					2'd0: wt_s1 <= '0;
					2'd1: wt_s1 <= h2x <<< 7;
					2'd2: wt_s1 <= h2x <<< 6;
					default: wt_s1 <= h2x <<< 5;
				endcase
			end
			S_DIV: prod_s2 <= 61'(zs[29:0]) * 61'(hsg3_pkg::DIV15_M);
			S_SUB: begin
				mix_s3 <= mixw[23:0];
				o_s3 <= 25'(mixw - 28'(cap_q));
			end
			S_FILT: ok_s4 <= 50'(o_s3) * 50'(signed'({1'b0, hsg3_pkg::FILTER_K}));
			S_CAP: res_q <= '{audio_sample: s15, channels_active: en_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= 2'd0;
			cps_q <= 26'd6233059;
			fps_q <= 24'd194782;
			for (int i = 0; i < hsg3_pkg::REG_NUM; i++) begin
				regs_q[i] <= hsg3_pkg::REG_RESET[i];
			end
			wvld_q <= '0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
				len_q[i] <= 9'd1;
				held_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				duty_q[i] <= '0;
				vol_q[i] <= '0;
				etm_q[i] <= '0;
			end
			wave_pos_q <= '0;
			shadow_q <= '0;
			sw_timer_q <= '0;
			sw_active_q <= 1'b0;
			en_q <= '0;
			facc_q <= 26'sd16777216;
			fs_q <= '0;
			cap_q <= signed'(hsg3_pkg::CAP_RESET);
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == hsg3_pkg::CFG_CLOCKS) begin
					cps_q <= cfg_data;
				end else begin
					fps_q <= cfg_data[23:0];
				end
			end
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tk_acc) begin
						ch_q <= 2'd0;
						state_q <= S_CH;
					end
					if (wr_acc) begin
						if (w_wave) begin
							wvld_q[off[hsg3_pkg::WAVE_AW-1:0]] <= 1'b1;
						end else if (off == hsg3_pkg::OFF_NR31) begin
							len_q[2] <= 9'd256 - {1'b0, wd};
						end else if (w_hit) begin
							regs_q[w_idx] <= wd;
							if (w_idx == hsg3_pkg::IDX_NR11) begin
								len_q[0] <= 9'd64 - {3'b000, wd[5:0]};
							end
							if (w_idx == hsg3_pkg::IDX_NR21) begin
								len_q[1] <= 9'd64 - {3'b000, wd[5:0]};
							end
							if (trig) begin
								en_q <= (en_q | (3'b001 << t_ch)) & ~{2'b00, t_dis};
								if (len_q[t_ch] == 9'd0) begin
									len_q[t_ch] <= (t_ch == 2'd2) ? 9'd256 : 9'd64;
								end
								acc_q[t_ch] <= period_of(t_f, t_ch == 2'd2);
								if (t_ch == 2'd0) begin
									shadow_q <= t_f;
									sw_timer_q <= per8;
									sw_active_q <= (regs_q[hsg3_pkg::IDX_NR10][6:4] != 3'd0) ||
										(regs_q[hsg3_pkg::IDX_NR10][2:0] != 3'd0);
								end
								if (t_ch == 2'd2) begin
									wave_pos_q <= '0;
								end else begin
									vol_q[t_ch[0]] <= t_env[7:4];
									etm_q[t_ch[0]] <= t_env[2:0];
								end
							end
						end
					end
				end
				S_CH: begin
					acc_q[ch_q] <= acc_new;
					if (fire) begin
						held_q[ch_q] <= lvl;
						if (ch_q == 2'd2) begin
							wave_pos_q <= wave_pos_q + 5'd1;
						end else begin
							duty_q[ch_q[0]] <= dpos + 3'd1;
						end
					end
					ch_q <= ch_q + 2'd1;
					if (ch_q == 2'd2) begin
						state_q <= S_FRAME;
					end
				end
				S_FRAME: begin
					facc_q <= facc_nx;
					if (fr_fire) begin
						fs_q <= fs_nx;
						en_q <= en_nx;
						for (int i = 0; i < 3; i++) begin
							len_q[i] <= len_nx[i];
						end
						for (int i = 0; i < 2; i++) begin
							vol_q[i] <= vol_nx[i];
							etm_q[i] <= etm_nx[i];
						end
						regs_q[hsg3_pkg::IDX_NR13] <= r3_nx;
						regs_q[hsg3_pkg::IDX_NR14] <= r4_nx;
						shadow_q <= shadow_nx;
						sw_timer_q <= swt_nx;
					end
					state_q <= S_MIX;
				end
				S_MIX: state_q <= S_DIV;
				S_DIV: state_q <= S_SUB;
				S_SUB: state_q <= S_FILT;
				S_FILT: state_q <= S_CAP;
				S_CAP: begin
					cap_q <= cap_nx;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`HSG3_CHK_NEXT(a_tick_starts, tk_acc, (state_q == S_CH) && (ch_q == 2'd0), "tick did not start channel pass")
	`HSG3_CHK_NEXT(a_ch_to_frame, (state_q == S_CH) && (ch_q == 2'd2), state_q == S_FRAME, "channel pass overran")
	`HSG3_CHK_NOW(a_ch_range, state_q == S_CH, ch_q != 2'd3, "channel index out of range")
	`HSG3_CHK_NEXT(a_write_one_cycle, wr_acc, state_q == S_IDLE, "write left idle")
	`HSG3_CHK_NEXT(a_done_loads, (state_q == S_DONE) && (!out_valid_q || !out_stall), out_valid_q && (state_q == S_IDLE), "result not loaded")

endmodule
